@@ hw/rtl/shf_pkg.sv @@
// ----------------------------------------------------------------------------
// shf_pkg: shared types and constants for the sync header frame deframer
// Phase and status codes, register indexes, reset values, queue sizing.
// ----------------------------------------------------------------------------
package shf_pkg;

   localparam int BYTE_W      = 8;
   localparam int SUM_W       = 16;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // register reset values
   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST     = 8'hEB;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST    = 8'h90;
   localparam logic [BYTE_W-1:0] PAYLOAD_LENGTH_RST = 8'd118;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAYLOAD_LENGTH = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT1   = 3'd0,
      PH_HUNT2   = 3'd1,
      PH_PAYLOAD = 3'd2,
      PH_CKLO    = 3'd3,
      PH_CKHI    = 3'd4
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_BUSY = 2'd0,
      ST_GOOD = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
      logic [BYTE_W-1:0] payload_length;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic [BYTE_W-1:0]   byte_position;
      logic                end_of_frame;
      logic [STATUS_W-1:0] frame_status;
   } rsp_item_type;

   // handoff between front parser and queue
   typedef struct packed {
      logic         push;
      rsp_item_type item;
   } push_type;

   // handoff between queue and output stage
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } head_type;

endpackage

@@ hw/rtl/shf_ifs.sv @@
// ----------------------------------------------------------------------------
// shf_ifs: channel interfaces of the deframer
// Received byte channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface shf_req_if;
   logic                      valid;
   logic                      ready;
   logic [shf_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [shf_pkg::BYTE_W-1:0]   data_byte;
   logic [shf_pkg::BYTE_W-1:0]   byte_position;
   logic                        end_of_frame;
   logic [shf_pkg::STATUS_W-1:0] frame_status;

   modport source (output valid, output data_byte, output byte_position,
                   output end_of_frame, output frame_status, input ready);
   modport sink   (input valid, input data_byte, input byte_position,
                   input end_of_frame, input frame_status, output ready);
endinterface

interface shf_csr_if;
   logic                           valid;
   logic                           ready;
   logic [shf_pkg::CSR_INDEX_W-1:0] index;
   logic [shf_pkg::BYTE_W-1:0]      wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ hw/rtl/sync_header_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// sync_header_frame_deframer: two-byte sync header frame parser
// Hunts for the header, tags payload bytes and checks the 16-bit sum.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries one received byte per beat. Header bytes and the
//    checksum low byte produce no result; each payload byte and the
//    checksum high byte produce exactly one beat on rsp_bus.
//  - rsp_bus: payload beats carry data and position with status busy; the
//    checksum high byte gives the last beat, end_of_frame set, position =
//    payload_length, status good or error.
//  - csr_bus: index 0 sync_first, 1 sync_second, 2 payload_length; index 3
//    is ignored. Always ready; write only while the block is idle.
//  - Throughput: one byte per cycle while the queue is not full. A result
//    is pushed into the queue at the edge that accepts its byte; the output
//    register then loads it from the queue head once that register is empty
//    or its held beat leaves.
//  - Stall: when rsp_bus is held off, results pile up in the 4-entry queue
//    plus the output register; req_bus.ready drops only when the queue is
//    full.
//  - Reset: parser back to hunting, queue and output emptied, registers
//    back to 0xEB, 0x90 and 118.
// ----------------------------------------------------------------------------
module sync_header_frame_deframer (
   input  logic      clock,
   input  logic      reset,
   shf_req_if.sink   req_bus,
   shf_rsp_if.source rsp_bus,
   shf_csr_if.sink   csr_bus
);
   import shf_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;
   logic     byte_fire;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_SYNC_FIRST:     cfg_in.sync_first     = csr_bus.wdata;
            CSR_SYNC_SECOND:    cfg_in.sync_second    = csr_bus.wdata;
            CSR_PAYLOAD_LENGTH: cfg_in.payload_length = csr_bus.wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first     <= SYNC_FIRST_RST;
         cfg_ff.sync_second    <= SYNC_SECOND_RST;
         cfg_ff.payload_length <= PAYLOAD_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input beat taken whenever the queue has room
   assign req_bus.ready = !queue_full;
   assign byte_fire     = req_bus.valid && !queue_full;

   shf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .rx_byte   (req_bus.rx_byte),
      .cfg       (cfg_ff),
      .push      (push)
   );

   shf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   shf_out_stage u_out (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ hw/rtl/shf_parser.sv @@
// ----------------------------------------------------------------------------
// shf_parser: front end of the deframer
// Byte-wise header hunt, payload tagging and checksum compare.
// ----------------------------------------------------------------------------
module shf_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       byte_fire,
   input  logic [shf_pkg::BYTE_W-1:0] rx_byte,
   input  shf_pkg::cfg_type           cfg,
   output shf_pkg::push_type          push
);
   import shf_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              low_ok_ff, low_ok_in;
   logic [BYTE_W:0]   taken;

   assign taken = {1'b0, count_ff} + {{BYTE_W{1'b0}}, 1'b1};

   // next state
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      low_ok_in = low_ok_ff;
      if (byte_fire) begin
         unique case (phase_ff)
            PH_HUNT2: begin
               if (rx_byte == cfg.sync_second) begin
                  sum_in    = {{(SUM_W-BYTE_W){1'b0}}, cfg.sync_first}
                            + {{(SUM_W-BYTE_W){1'b0}}, cfg.sync_second};
                  count_in  = '0;
                  low_ok_in = 1'b0;
                  phase_in  = (cfg.payload_length == '0) ? PH_CKLO : PH_PAYLOAD;
               end else if (rx_byte != cfg.sync_first) begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_PAYLOAD: begin
               sum_in   = sum_ff + {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
               count_in = taken[BYTE_W-1:0];
               if (taken >= {1'b0, cfg.payload_length}) begin
                  phase_in = PH_CKLO;
               end
            end
            PH_CKLO: begin
               low_ok_in = (rx_byte == sum_ff[BYTE_W-1:0]);
               phase_in  = PH_CKHI;
            end
            PH_CKHI: begin
               phase_in  = PH_HUNT1;
               count_in  = '0;
               sum_in    = '0;
               low_ok_in = 1'b0;
            end
            default: begin
               phase_in = (rx_byte == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
         endcase
      end
   end

   // result for the accepted byte
   always_comb begin
      push.push               = 1'b0;
      push.item.data_byte     = rx_byte;
      push.item.byte_position = count_ff;
      push.item.end_of_frame  = 1'b0;
      push.item.frame_status  = ST_BUSY;
      unique case (phase_ff)
         PH_PAYLOAD: begin
            push.push = byte_fire;
         end
         PH_CKHI: begin
            push.push               = byte_fire;
            push.item.byte_position = cfg.payload_length;
            push.item.end_of_frame  = 1'b1;
            push.item.frame_status  =
               (low_ok_ff && (rx_byte == sum_ff[SUM_W-1:BYTE_W])) ? ST_GOOD : ST_BAD;
         end
         default: begin
            push.push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT1;
         count_ff  <= '0;
         sum_ff    <= '0;
         low_ok_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         low_ok_ff <= low_ok_in;
      end
   end

endmodule

@@ hw/rtl/shf_queue.sv @@
// ----------------------------------------------------------------------------
// shf_queue: short result queue between parser and output stage
// Circular buffer; full flag throttles the byte input.
// ----------------------------------------------------------------------------
module shf_queue (
   input  logic              clock,
   input  logic              reset,
   input  shf_pkg::push_type push,
   input  logic              pop,
   output shf_pkg::head_type head,
   output logic              full
);
   import shf_pkg::*;

   rsp_item_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/shf_out_stage.sv @@
// ----------------------------------------------------------------------------
// shf_out_stage: back end of the deframer
// Output register of the result channel, refilled from the queue head.
// ----------------------------------------------------------------------------
module shf_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  shf_pkg::head_type head,
   output logic              pop,
   shf_rsp_if.source         rsp_bus
);
   import shf_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // load when empty or when the held beat leaves this cycle
   assign pop      = head.valid && (!valid_ff || rsp_bus.ready);
   assign valid_in = pop ? 1'b1 : (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head.item;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.data_byte     = item_ff.data_byte;
   assign rsp_bus.byte_position = item_ff.byte_position;
   assign rsp_bus.end_of_frame  = item_ff.end_of_frame;
   assign rsp_bus.frame_status  = item_ff.frame_status;

endmodule

@@ sim/shf_frame_checker.sv @@
// ----------------------------------------------------------------------------
// shf_frame_checker: scoreboard for the sync header frame deframer
// Watches the byte, result and register channels, runs its own copy of the
// frame parser on every accepted byte and compares each result beat in order.
// ----------------------------------------------------------------------------
module shf_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [shf_pkg::BYTE_W-1:0]      req_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [shf_pkg::BYTE_W-1:0]      rsp_data,
   input  logic [shf_pkg::BYTE_W-1:0]      rsp_pos,
   input  logic                            rsp_eof,
   input  logic [shf_pkg::STATUS_W-1:0]    rsp_status,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [shf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [shf_pkg::BYTE_W-1:0]      csr_wdata,
   output int                              check_errors,
   output int                              beats_pending,
   output int                              beats_checked,
   output int                              frames_good,
   output int                              frames_bad
);
   timeunit 1ns;
   timeprecision 1ps;
   import shf_pkg::*;

   // parser copy
   cfg_type           cfg;
   phase_type         phase;
   logic [BYTE_W-1:0] pay_count;
   logic [SUM_W-1:0]  sum_acc;
   logic              lo_ok;

   rsp_item_type beats_due[$];
   rsp_item_type got_beat;
   rsp_item_type want_beat;
   rsp_item_type new_beat;
   logic         new_emit;

   int errors  = 0;
   int shown   = 0;
   int checked = 0;
   int n_good  = 0;
   int n_bad   = 0;

   task automatic start_hunt();
      phase     = PH_HUNT1;
      pay_count = '0;
      sum_acc   = '0;
      lo_ok     = 1'b0;
   endtask

   // one received byte through the parser; emit set when a beat is due
   task automatic deframe_byte(input logic [BYTE_W-1:0] b, output logic emit,
                               output rsp_item_type beat);
      logic [BYTE_W:0] taken;
      logic            good;
      emit = 1'b0;
      beat = '0;
      case (phase)
         PH_HUNT2: begin
            if (b == cfg.sync_second) begin
               sum_acc   = {8'h00, cfg.sync_first} + {8'h00, cfg.sync_second};
               pay_count = '0;
               lo_ok     = 1'b0;
               phase     = (cfg.payload_length == '0) ? PH_CKLO : PH_PAYLOAD;
            end else if (b != cfg.sync_first) begin
               phase = PH_HUNT1;
            end
         end
         PH_PAYLOAD: begin
            taken              = {1'b0, pay_count} + 1'b1;
            emit               = 1'b1;
            beat.data_byte     = b;
            beat.byte_position = pay_count;
            beat.end_of_frame  = 1'b0;
            beat.frame_status  = ST_BUSY;
            sum_acc            = sum_acc + {8'h00, b};
            // length is read live, so a shorter value ends the payload now
            if (taken >= {1'b0, cfg.payload_length})
               phase = PH_CKLO;
            pay_count = taken[BYTE_W-1:0];
         end
         PH_CKLO: begin
            lo_ok = (b == sum_acc[7:0]);
            phase = PH_CKHI;
         end
         PH_CKHI: begin
            good               = lo_ok && (b == sum_acc[15:8]);
            emit               = 1'b1;
            beat.data_byte     = b;
            beat.byte_position = cfg.payload_length;
            beat.end_of_frame  = 1'b1;
            beat.frame_status  = good ? ST_GOOD : ST_BAD;
            start_hunt();
         end
         default: begin
            phase = (b == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.sync_first     = SYNC_FIRST_RST;
         cfg.sync_second    = SYNC_SECOND_RST;
         cfg.payload_length = PAYLOAD_LENGTH_RST;
         start_hunt();
         beats_due.delete();
      end else begin
         // result side first: a byte taken at this edge cannot show yet
         if (rsp_valid && rsp_ready) begin
            got_beat.data_byte     = rsp_data;
            got_beat.byte_position = rsp_pos;
            got_beat.end_of_frame  = rsp_eof;
            got_beat.frame_status  = rsp_status;
            checked++;
            if (rsp_eof === 1'b1 && rsp_status === ST_GOOD) n_good++;
            if (rsp_eof === 1'b1 && rsp_status === ST_BAD)  n_bad++;
            if (beats_due.size() == 0) begin
               errors++;
               if (shown < 10)
                  $display("%0t: unexpected beat data %h pos %0d eof %b status %0d",
                           $realtime, rsp_data, rsp_pos, rsp_eof, rsp_status);
               shown++;
            end else begin
               want_beat = beats_due.pop_front();
               if (got_beat.data_byte     !== want_beat.data_byte     ||
                   got_beat.byte_position !== want_beat.byte_position ||
                   got_beat.end_of_frame  !== want_beat.end_of_frame  ||
                   got_beat.frame_status  !== want_beat.frame_status) begin
                  errors++;
                  if (shown < 10)
                     $display("%0t: beat mismatch: want data %h pos %0d eof %b status %0d,",
                              $realtime, want_beat.data_byte,
                              want_beat.byte_position,
                              want_beat.end_of_frame, want_beat.frame_status,
                              " got data %h pos %0d eof %b status %0d",
                              got_beat.data_byte, got_beat.byte_position,
                              got_beat.end_of_frame, got_beat.frame_status);
                  shown++;
               end
            end
         end
         if (req_valid && req_ready) begin
            deframe_byte(req_byte, new_emit, new_beat);
            if (new_emit) beats_due.push_back(new_beat);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYNC_FIRST:     cfg.sync_first     = csr_wdata;
               CSR_SYNC_SECOND:    cfg.sync_second    = csr_wdata;
               CSR_PAYLOAD_LENGTH: cfg.payload_length = csr_wdata;
               default: ;
            endcase
         end
      end
      check_errors  <= errors;
      beats_pending <= beats_due.size();
      beats_checked <= checked;
      frames_good   <= n_good;
      frames_bad    <= n_bad;
   end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: top level for the sync header frame deframer
// Drives received bytes and register writes, throttles the result side and
// gives the verdict; checking is left to the frame checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import shf_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;  // ignored index
   localparam int RANDOM_BYTES  = 1450;
   localparam int SETTLE_CYCLES = 4;    // extra wait in drain, for bytes without a result
   localparam int HOLD_CYCLES   = 150;  // long result hold-off, fills the queue

   typedef enum {
      FR_GOOD,
      FR_BAD_LO,
      FR_BAD_HI,
      FR_BAD_BOTH
   } frame_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   shf_req_if req_bus ();
   shf_rsp_if rsp_bus ();
   shf_csr_if csr_bus ();

   int check_errors;
   int beats_pending;
   int beats_checked;
   int frames_good;
   int frames_bad;

   // what the stimulus believes the registers hold
   logic [BYTE_W-1:0] sf;
   logic [BYTE_W-1:0] ss;
   logic [BYTE_W-1:0] plen;

   int bytes_sent    = 0;
   int settings_done = 0;
   int random_stop;
   int phase_no;
   int nframes;
   int roll;
   int rsp_roll;
   int k;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_req    = 1'b0;
   int hold_left   = 0;
   int stall_left  = 0;
   logic [SUM_W-1:0]  mid_sum;
   logic [BYTE_W-1:0] pick_sf;
   logic [BYTE_W-1:0] pick_ss;
   logic [BYTE_W-1:0] pick_len;
   frame_kind_type    fk;

   always #5 clock = ~clock;

   sync_header_frame_deframer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   shf_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_byte      (req_bus.rx_byte),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_data      (rsp_bus.data_byte),
      .rsp_pos       (rsp_bus.byte_position),
      .rsp_eof       (rsp_bus.end_of_frame),
      .rsp_status    (rsp_bus.frame_status),
      .csr_valid     (csr_bus.valid),
      .csr_ready     (csr_bus.ready),
      .csr_index     (csr_bus.index),
      .csr_wdata     (csr_bus.wdata),
      .check_errors  (check_errors),
      .beats_pending (beats_pending),
      .beats_checked (beats_checked),
      .frames_good   (frames_good),
      .frames_bad    (frames_bad)
   );

   // payload content, with the two extremes weighted up
   function automatic logic [BYTE_W-1:0] rand_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 8'h00;
      if (r < 20) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // a random byte that is neither header value, so hunting stays put
   function automatic logic [BYTE_W-1:0] other_byte();
      logic [BYTE_W-1:0] y;
      y = 8'($urandom_range(0, 255));
      while (y == sf || y == ss) y = y + 8'd1;
      return y;
   endfunction

   // sender gap: mostly none, sometimes a short one, now and then a long one
   function automatic int req_gap();
      int r;
      if (!req_idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // one byte beat; valid stays high into the next byte when no gap follows
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      bytes_sent++;
      gap = req_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender stops and waits until every predicted beat is back, then a little
   // longer so bytes without a result have cleared the parser too
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (beats_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write beat; caller lowers valid after the last one
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [BYTE_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_SYNC_FIRST:     sf   = data;
         CSR_SYNC_SECOND:    ss   = data;
         CSR_PAYLOAD_LENGTH: plen = data;
         default: ;
      endcase
   endtask

   task automatic program_config(input logic [BYTE_W-1:0] f,
                                 input logic [BYTE_W-1:0] s,
                                 input logic [BYTE_W-1:0] len);
      csr_write(CSR_SYNC_FIRST, f);
      csr_write(CSR_SYNC_SECOND, s);
      csr_write(CSR_PAYLOAD_LENGTH, len);
      if ($urandom_range(0, 2) == 0) csr_write(CSR_SPARE, rand_byte());
      csr_bus.valid <= 1'b0;
      settings_done++;
   endtask

   // full frame under the current registers; recheck puts a doubled first
   // header byte in front when the header bytes differ, a fresh start to the parser
   task automatic send_frame(input frame_kind_type kind, input bit recheck);
      logic [SUM_W-1:0]  s;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      send_byte(sf);
      if (recheck && sf != ss) send_byte(sf);
      send_byte(ss);
      s = {8'h00, sf} + {8'h00, ss};
      for (int n = 0; n < int'(plen); n++) begin
         b = rand_byte();
         send_byte(b);
         s = s + {8'h00, b};
      end
      lo = s[7:0];
      hi = s[15:8];
      if (kind == FR_BAD_LO || kind == FR_BAD_BOTH) lo = lo ^ 8'($urandom_range(1, 255));
      if (kind == FR_BAD_HI || kind == FR_BAD_BOTH) hi = hi ^ 8'($urandom_range(1, 255));
      send_byte(lo);
      send_byte(hi);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_roll = $urandom_range(0, 99);
            if (rsp_idle_on && rsp_roll < 12) begin
               rsp_bus.ready <= 1'b0;
               stall_left = $urandom_range(0, 2);
            end else if (rsp_idle_on && rsp_roll < 14) begin
               rsp_bus.ready <= 1'b0;
               stall_left = $urandom_range(9, 29);
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= '0;
      csr_bus.wdata   <= '0;
      sf   = SYNC_FIRST_RST;
      ss   = SYNC_SECOND_RST;
      plen = PAYLOAD_LENGTH_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: short payload, reset header values ----
      csr_write(CSR_PAYLOAD_LENGTH, 8'd2);
      csr_bus.valid <= 1'b0;
      send_frame(FR_GOOD, 1'b1);     // doubled first header byte
      send_byte(8'h00);              // line noise while hunting
      send_byte(8'hFF);
      send_byte(sf);                 // header broken by a wrong second byte
      send_byte(8'h00);
      send_frame(FR_BAD_LO, 1'b0);
      send_frame(FR_BAD_HI, 1'b0);

      // zero length: header straight into the checksum bytes
      drain();
      csr_write(CSR_PAYLOAD_LENGTH, 8'd0);
      csr_bus.valid <= 1'b0;
      send_frame(FR_GOOD, 1'b0);

      // length cut below the count taken while parked mid-payload
      drain();
      csr_write(CSR_PAYLOAD_LENGTH, 8'd3);
      csr_bus.valid <= 1'b0;
      send_byte(sf);
      send_byte(ss);
      send_byte(8'hAA);
      send_byte(8'h55);
      drain();
      csr_write(CSR_PAYLOAD_LENGTH, 8'd1);
      csr_bus.valid <= 1'b0;
      send_byte(8'h5A);
      mid_sum = {8'h00, sf} + {8'h00, ss} + 16'h00AA + 16'h0055 + 16'h005A;
      send_byte(mid_sum[7:0]);
      send_byte(mid_sum[15:8]);

      // ---- random phases, each under fresh register values ----
      random_stop = bytes_sent + RANDOM_BYTES;
      phase_no = 0;
      while (bytes_sent < random_stop) begin
         drain();
         case (phase_no)
            0: begin pick_sf = rand_byte(); pick_ss = other_byte(); pick_len = 8'd255; end
            1: begin pick_sf = rand_byte(); pick_ss = other_byte(); pick_len = 8'd0;   end
            2: begin
               pick_sf = SYNC_FIRST_RST; pick_ss = SYNC_SECOND_RST;
               pick_len = PAYLOAD_LENGTH_RST;
            end
            3: begin
               pick_sf = 8'($urandom_range(0, 255)); pick_ss = pick_sf;
               pick_len = 8'($urandom_range(1, 6));
            end
            4: begin pick_sf = 8'h00; pick_ss = 8'hFF; pick_len = 8'd1; end
            5: begin pick_sf = 8'hFF; pick_ss = 8'h00; pick_len = 8'($urandom_range(1, 8)); end
            default: begin
               pick_sf = 8'($urandom_range(0, 255));
               pick_ss = 8'($urandom_range(0, 255));
               roll = $urandom_range(0, 99);
               if (roll < 80)      pick_len = 8'($urandom_range(1, 8));
               else if (roll < 95) pick_len = 8'($urandom_range(9, 40));
               else                pick_len = 8'd0;
            end
         endcase
         program_config(pick_sf, pick_ss, pick_len);

         // some phases run without gaps on one side or both
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (phase_no == 0) begin
            // long frame against a stalled receiver: queue fills, input backs up
            req_idle_on = 1'b0;
            hold_req = 1'b1;
         end

         nframes = $urandom_range(1, 1 + 60 / (int'(plen) + 4));
         for (k = 0; k < nframes; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
               send_byte(sf);
               send_byte(other_byte());
            end else if (roll < 12) begin
               repeat ($urandom_range(1, 3)) send_byte(other_byte());
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 70)      fk = FR_GOOD;
               else if (roll < 80) fk = FR_BAD_LO;
               else if (roll < 90) fk = FR_BAD_HI;
               else                fk = FR_BAD_BOTH;
               send_frame(fk, $urandom_range(0, 99) < 15);
            end
            // occasional full stop on the sender mid-phase
            if ($urandom_range(0, 99) < 5) drain();
         end
         phase_no++;
      end

      drain();
      $display("Covered %0d bytes under %0d register settings plus directed cases.",
               bytes_sent, settings_done);
      $display("Checked %0d result beats, %0d frames good and %0d with checksum error.",
               beats_checked, frames_good, frames_bad);
      if (check_errors == 0 && beats_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
